// ===== design/median5_deadband_filter_defines.svh =====
// Assertion macros for the median-5 deadband filter.
// Define ASSERT_OFF to compile all checks out.
`ifndef MEDIAN5_DEADBAND_FILTER_DEFINES_SVH
`define MEDIAN5_DEADBAND_FILTER_DEFINES_SVH

`ifndef ASSERT_OFF

// Immediate-relation check, sampled on the rising clock edge.
`define MDB_ASSERT(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Implication check, sampled on the rising clock edge.
`define MDB_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication check, sampled on the rising clock edge.
`define MDB_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define MDB_ASSERT(lbl, clk, rst, expr, msg)
`define MDB_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define MDB_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ===== design/mdb_pkg.sv =====
`timescale 1ns / 1ps

package mdb_pkg;

  // Default sample width
  localparam int SAMPLE_BITS_DEF = 16;

  // Window length and the sorted position of its median
  localparam int WIN_LEN    = 5;
  localparam int MEDIAN_IDX = 2;

  // Fill counter wide enough to hold WIN_LEN itself
  localparam int FILL_BITS = $clog2(WIN_LEN + 1);

  // Hold threshold register
  localparam int                  THR_BITS  = 16;
  localparam logic [THR_BITS-1:0] THR_RESET = THR_BITS'(3);

  typedef logic [FILL_BITS-1:0] fill_t;
  typedef logic [THR_BITS-1:0]  thr_t;

endpackage

// ===== design/mdb_if.sv =====
`timescale 1ns / 1ps

// Sample channel: one raw sample per beat
interface mdb_sample_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

// Result channel: one filtered value per beat
interface mdb_filtered_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] filtered;

  modport source (output valid, output filtered, input ready);
  modport sink (input valid, input filtered, output ready);
endinterface

// ===== design/mdb_cell.sv =====
`timescale 1ns / 1ps

// One window cell: holds a sample and takes its left neighbor's on a shift
module mdb_cell
  import mdb_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   shift,
  input  logic [SAMPLE_BITS-1:0] din,
  output logic [SAMPLE_BITS-1:0] dout
);

  logic [SAMPLE_BITS-1:0] value;

  // Advance the chain by one position
  always_ff @(posedge clk) begin
    if (shift) begin
      value <= din;
    end
  end

  assign dout = value;

endmodule

// ===== design/mdb_median5.sv =====
`timescale 1ns / 1ps

// Median of five through a nine-comparator sorting network
module mdb_median5
  import mdb_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic [SAMPLE_BITS-1:0] win [WIN_LEN],
  output logic [SAMPLE_BITS-1:0] median
);

  logic [SAMPLE_BITS-1:0] v [WIN_LEN];
  logic [SAMPLE_BITS-1:0] t;

  // Sort in place, six levels deep; take the middle element
  always_comb begin
    t = '0;
    for (int i = 0; i < WIN_LEN; i++) begin
      v[i] = win[i];
    end
    // level 1
    if (v[0] > v[1]) begin t = v[0]; v[0] = v[1]; v[1] = t; end
    if (v[3] > v[4]) begin t = v[3]; v[3] = v[4]; v[4] = t; end
    // level 2
    if (v[2] > v[4]) begin t = v[2]; v[2] = v[4]; v[4] = t; end
    // level 3
    if (v[2] > v[3]) begin t = v[2]; v[2] = v[3]; v[3] = t; end
    if (v[1] > v[4]) begin t = v[1]; v[1] = v[4]; v[4] = t; end
    // level 4
    if (v[0] > v[3]) begin t = v[0]; v[0] = v[3]; v[3] = t; end
    // level 5
    if (v[0] > v[2]) begin t = v[0]; v[0] = v[2]; v[2] = t; end
    if (v[1] > v[3]) begin t = v[1]; v[1] = v[3]; v[3] = t; end
    // level 6
    if (v[1] > v[2]) begin t = v[1]; v[1] = v[2]; v[2] = t; end
    median = v[MEDIAN_IDX];
  end

endmodule

// ===== design/median5_deadband_filter.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Payload                Beat
// samples   in   sample[SAMPLE_BITS]    one raw sample
// results   out  filtered[SAMPLE_BITS]  held output after that sample
// cfg       in   cfg_wdata[16]          hold threshold, written when cfg_we
//
// One sample per cycle unless results stalls; each result passes through cell 0, cand and held.
// Stage one is the five-cell sample chain, stage two the median network,
// stage three the deadband compare against the held output register.
// Reset empties the pipeline, clears the fill count and held state, and loads
// the threshold with 3. A stall on results freezes all stages and drops ready.

`include "median5_deadband_filter_defines.svh"

module median5_deadband_filter
  import mdb_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [THR_BITS-1:0]   cfg_wdata,
  mdb_sample_if.sink            samples,
  mdb_filtered_if.source        results
);

  localparam int CMP_W = (SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS;

  logic                   advance;
  logic                   take;
  thr_t                   threshold;
  logic [SAMPLE_BITS-1:0] cell_q [WIN_LEN];
  logic [SAMPLE_BITS-1:0] median;
  fill_t                  fill;
  logic                   v1;
  logic                   v2;
  logic                   v3;
  logic [SAMPLE_BITS-1:0] cand;
  logic [SAMPLE_BITS-1:0] cand_next;
  logic [SAMPLE_BITS-1:0] held;
  logic                   held_valid;
  logic [SAMPLE_BITS-1:0] diff;
  logic                   update;

  // Whole pipeline moves unless a finished result is stalled
  assign advance       = !v3 || results.ready;
  assign samples.ready = advance;
  assign take          = samples.valid && advance;

  // Hold threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THR_RESET;
    end else if (cfg_we) begin
      threshold <= cfg_wdata;
    end
  end

  // Sample chain: cell 0 takes the new beat, the rest take their neighbor
  for (genvar i = 0; i < WIN_LEN; i++) begin : g_cell
    if (i == 0) begin : g_head
      mdb_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
        .clk   (clk),
        .shift (take),
        .din   (samples.sample),
        .dout  (cell_q[i])
      );
    end else begin : g_body
      mdb_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
        .clk   (clk),
        .shift (take),
        .din   (cell_q[i-1]),
        .dout  (cell_q[i])
      );
    end
  end

  // Count samples up to a full window
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      v1   <= 1'b0;
    end else if (advance) begin
      v1 <= samples.valid;
      if (samples.valid && fill < FILL_BITS'(WIN_LEN)) begin
        fill <= fill + FILL_BITS'(1);
      end
    end
  end

  mdb_median5 #(.SAMPLE_BITS(SAMPLE_BITS)) u_median (
    .win    (cell_q),
    .median (median)
  );

  // Raw sample until the window is full, median after
  assign cand_next = (fill < FILL_BITS'(WIN_LEN)) ? cell_q[0] : median;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (advance) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && v1) begin
      cand <= cand_next;
    end
  end

  // Deadband: replace the held value on a large enough move
  assign diff   = (cand >= held) ? (cand - held) : (held - cand);
  assign update = !held_valid || (CMP_W'(diff) >= CMP_W'(threshold));

  always_ff @(posedge clk) begin
    if (rst) begin
      v3         <= 1'b0;
      held       <= '0;
      held_valid <= 1'b0;
    end else if (advance) begin
      v3 <= v2;
      if (v2) begin
        held_valid <= 1'b1;
        if (update) begin
          held <= cand;
        end
      end
    end
  end

  assign results.valid    = v3;
  assign results.filtered = held;

  // Checks
  `MDB_ASSERT(a_fill_range, clk, rst, fill <= FILL_BITS'(WIN_LEN), "fill count past window")
  `MDB_ASSERT_IMP(a_held_set, clk, rst, results.valid, held_valid, "result without held value")
  `MDB_ASSERT_NXT(a_beat_enters, clk, rst, samples.valid && samples.ready, v1, "beat lost at entry")
  `MDB_ASSERT_NXT(a_stall_hold, clk, rst, v3 && !results.ready, $stable(held) && v3,
                  "held value moved during stall")

endmodule
